[sv/iidl_pkg.sv]
// ----------------------------------------------------------------------------
// iidl_pkg
// shared types, codes and defaults for the indexed insert/delete list
// ----------------------------------------------------------------------------
package iidl_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int KIND_W  = 3;
    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int LEN_W   = 5;
    localparam int STAT_W  = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_START  = 3'd0,
        KIND_SET    = 3'd1,
        KIND_ERASE  = 3'd2,
        KIND_INSERT = 3'd3,
        KIND_PUSH   = 3'd4,
        KIND_READ   = 3'd5
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_START,
        ACT_SET,
        ACT_ERASE,
        ACT_INSERT,
        ACT_PUSH,
        ACT_READ
    } t_act;

    // what the sequencer does with an accepted beat
    typedef struct packed {
        t_act    act;
        t_status status;
        logic    moves;   // entries have to shift before the op completes
    } t_plan;

endpackage

[sv/iidl_ram.sv]
// ----------------------------------------------------------------------------
// iidl_ram
// generic simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module iidl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/iidl_check.sv]
// ----------------------------------------------------------------------------
// iidl_check
// bounds and capacity checks, turns a command beat into a plan
// ----------------------------------------------------------------------------
module iidl_check
    import iidl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic [KIND_W-1:0] i_kind,
    input  logic [POS_W-1:0]  i_position,
    input  logic [CW-1:0]     i_count,
    output t_plan             o_plan
);

    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic [CMPW-1:0] pos_x;
    logic [CMPW-1:0] cnt_x;
    logic [CMPW-1:0] depth_x;
    logic            full;

    assign pos_x   = CMPW'(i_position);
    assign cnt_x   = CMPW'(i_count);
    assign depth_x = CMPW'(DEPTH);
    assign full    = (cnt_x == depth_x);

    always_comb begin
        o_plan.act    = ACT_NONE;
        o_plan.status = ST_DONE;
        o_plan.moves  = 1'b0;
        unique case (t_kind'(i_kind))
            KIND_START: begin
                if (pos_x > depth_x) o_plan.status = ST_RANGE;
                else                 o_plan.act    = ACT_START;
            end
            KIND_SET: begin
                if (pos_x >= cnt_x) o_plan.status = ST_RANGE;
                else                o_plan.act    = ACT_SET;
            end
            KIND_ERASE: begin
                if (pos_x >= cnt_x) begin
                    o_plan.status = ST_RANGE;
                end else begin
                    o_plan.act   = ACT_ERASE;
                    o_plan.moves = (pos_x + CMPW'(1) != cnt_x);
                end
            end
            KIND_INSERT: begin
                if (pos_x > cnt_x) begin
                    o_plan.status = ST_RANGE;
                end else if (full) begin
                    o_plan.status = ST_FULL;
                end else begin
                    o_plan.act   = ACT_INSERT;
                    o_plan.moves = (pos_x != cnt_x);
                end
            end
            KIND_PUSH: begin
                if (full) o_plan.status = ST_FULL;
                else      o_plan.act    = ACT_PUSH;
            end
            KIND_READ: begin
                if (pos_x >= cnt_x) o_plan.status = ST_RANGE;
                else                o_plan.act    = ACT_READ;
            end
            default: begin
                // unused kinds: ignored, report done
                o_plan.act = ACT_NONE;
            end
        endcase
    end

endmodule

[sv/indexed_insert_delete_list_core.sv]
// ----------------------------------------------------------------------------
// indexed_insert_delete_list_core
// fixed-capacity ordered list of signed words with insert, erase and read
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low, and exactly one
// result beat follows, marked by o_done for a single cycle; the receiver
// cannot stall it, so it must take every result as it comes. Start, set, push,
// insert at the tail, erase of the last entry, refused commands and unused
// kinds finish at once: the result shows in the next cycle and busy never
// rises, so such commands can be issued every cycle. A read holds busy while
// in S_READ (the list ram has a registered read port), and its result is
// registered as it leaves that state. Erase at position p of a list of n entries
// moves the n-1-p entries above p, insert at p moves the n-p entries from p
// up: the entries are moved one at a time through the single read and write
// port of the ram, a read then a write per entry, and an insert ends in S_FILL,
// writing the new word. No clearing pass is needed after reset; an entry that
// was never written holds whatever the ram powered up with.
// ----------------------------------------------------------------------------
module indexed_insert_delete_list_core
    import iidl_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command beat
    input  logic               start,
    output logic               busy,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [POS_W-1:0]   i_position,
    input  logic signed [VALUE_W-1:0] i_value,
    // result beat
    output logic               o_done,
    output logic signed [VALUE_W-1:0] o_read_value,
    output logic [LEN_W-1:0]   o_length,
    output logic [STAT_W-1:0]  o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MOVE_RD,
        S_MOVE_WR,
        S_FILL
    } t_state;

    // sequencer state
    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [AW-1:0]           r_idx, n_idx;     // slot written by the next move
    logic [AW-1:0]           r_end, n_end;     // slot where moving stops
    logic                    r_dir, n_dir;     // 1: moving up (insert)
    logic [DATA_WIDTH-1:0]   r_word, n_word;   // word held for the insert fill

    // result registers
    logic                    r_done, n_done;
    logic signed [VALUE_W-1:0] r_rdv, n_rdv;
    logic [LEN_W-1:0]        r_len, n_len;
    t_status                 r_stat, n_stat;

    // ram ports
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [DATA_WIDTH-1:0]   ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [DATA_WIDTH-1:0]   ram_rdata;

    logic                    accept;
    t_plan                   plan;
    logic [AW-1:0]           pos_a;
    logic [AW-1:0]           cnt_a;
    logic [AW-1:0]           src;
    logic [63:0]             value_ext;
    logic [DATA_WIDTH-1:0]   in_word;
    logic signed [DATA_WIDTH-1:0] rd_word;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // slot indexes; in-range positions always fit the address width
    assign pos_a = AW'(i_position);
    assign cnt_a = AW'(r_count);

    // shared step unit: source slot of the current move
    assign src = r_dir ? (r_idx - AW'(1)) : (r_idx + AW'(1));

    // incoming word keeps its low DATA_WIDTH bits
    assign value_ext = {32'd0, i_value};
    assign in_word   = value_ext[DATA_WIDTH-1:0];

    // stored word back out, sign-extended from DATA_WIDTH then cut to 32 bits
    assign rd_word = $signed(ram_rdata);

    iidl_check #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_check (
        .i_kind     (i_kind),
        .i_position (i_position),
        .i_count    (r_count),
        .o_plan     (plan)
    );

    iidl_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_end     = r_end;
        n_dir     = r_dir;
        n_word    = r_word;
        n_done    = 1'b0;
        n_rdv     = '0;
        n_stat    = ST_DONE;
        n_len     = r_len;
        ram_we    = 1'b0;
        ram_waddr = pos_a;
        ram_wdata = in_word;
        ram_raddr = src;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_stat = plan.status;
                    unique case (plan.act)
                        ACT_NONE: begin
                            n_done = 1'b1;
                        end
                        ACT_START: begin
                            n_count = CW'(i_position);
                            n_done  = 1'b1;
                        end
                        ACT_SET: begin
                            ram_we = 1'b1;
                            n_done = 1'b1;
                        end
                        ACT_PUSH: begin
                            ram_we    = 1'b1;
                            ram_waddr = cnt_a;
                            n_count   = r_count + CW'(1);
                            n_done    = 1'b1;
                        end
                        ACT_ERASE: begin
                            n_count = r_count - CW'(1);
                            if (plan.moves) begin
                                // shift the entries above the hole down
                                n_idx   = pos_a;
                                n_end   = AW'(r_count - CW'(1));
                                n_dir   = 1'b0;
                                n_state = S_MOVE_RD;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        ACT_INSERT: begin
                            n_count = r_count + CW'(1);
                            if (plan.moves) begin
                                // open a gap at the position, top entry first
                                n_idx   = cnt_a;
                                n_end   = pos_a;
                                n_dir   = 1'b1;
                                n_word  = in_word;
                                n_state = S_MOVE_RD;
                            end else begin
                                ram_we = 1'b1;
                                n_done = 1'b1;
                            end
                        end
                        ACT_READ: begin
                            ram_raddr = pos_a;
                            n_state   = S_READ;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_rdv   = VALUE_W'(64'(rd_word));
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_MOVE_RD: begin
                ram_raddr = src;
                n_state   = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = ram_rdata;
                n_idx     = src;
                if (src == r_end) begin
                    if (r_dir) begin
                        n_state = S_FILL;
                    end else begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_MOVE_RD;
                end
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_end;
                ram_wdata = r_word;
                n_done    = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (n_done) begin
            n_len = LEN_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_idx  <= n_idx;
        r_end  <= n_end;
        r_dir  <= n_dir;
        r_word <= n_word;
        r_rdv  <= n_rdv;
        r_len  <= n_len;
        r_stat <= n_stat;
    end

    assign o_done       = r_done;
    assign o_read_value = r_rdv;
    assign o_length     = r_len;
    assign o_status     = r_stat;

    // length never grows past capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("list length beyond capacity");

    // every accepted beat either answers next cycle or keeps the block busy
    a_accept_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_done || busy))
        else $error("accepted beat left without result or busy");

    // the end of a multi-cycle command comes with its result beat
    a_busy_end_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result beat");

    // a refused command leaves the length alone
    a_refuse_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_DONE)) |-> $stable(r_count))
        else $error("refused command changed the length");

endmodule

[bench/indexed_insert_delete_list_core_test.sv]
// ----------------------------------------------------------------------------
// indexed_insert_delete_list_core_test
// self-checking bench for the fixed-capacity insert/erase list core
// ----------------------------------------------------------------------------
// Commands are queued up front by an initial block and fed to the core in
// random bursts. A shadow copy of the list predicts every result beat at the
// moment a command beat is taken, and the monitor checks the result strobes
// against those predictions in order. The generator keeps its own copy of the
// list so that it never reads a slot that was never written.
// ----------------------------------------------------------------------------
module indexed_insert_delete_list_core_test;
    import iidl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH   = DEPTH_DEF;
    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_CMDS  = 1125;
    localparam int SETTLE_CYCLES = 80;
    // slowest beat is an insert at the head of a 15 entry list
    localparam int RUN_LIMIT    = 400000;
    localparam int REPORT_MAX   = 10;

    // kinds the core has to ignore
    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
        bit                 hold;    // wait for an idle core before this beat
    } t_cmd;

    typedef struct packed {
        logic [VALUE_W-1:0] rd;
        logic [LEN_W-1:0]   len;
        logic [STAT_W-1:0]  status;
    } t_outcome;

    // shadow of the list: words, which slots hold a written word, and length
    typedef struct packed {
        logic [LIST_DEPTH-1:0][VALUE_W-1:0] words;
        logic [LIST_DEPTH-1:0]              known;
        logic [LEN_W-1:0]                   count;
    } t_list_image;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [KIND_W-1:0]         i_kind;
    logic [POS_W-1:0]          i_position;
    logic signed [VALUE_W-1:0] i_value;
    logic                      o_done;
    logic signed [VALUE_W-1:0] o_read_value;
    logic [LEN_W-1:0]          o_length;
    logic [STAT_W-1:0]         o_status;

    t_cmd        cmd_backlog[$];     // commands not yet put on the bus
    t_outcome    outcome_fifo[$];    // predicted result beats, oldest first
    t_list_image gen_image;          // list as the generator sees it
    t_list_image core_image;         // list as the taken beats leave it

    int unsigned cmd_total;
    int unsigned beats_sent;
    int unsigned beats_in;
    int unsigned cycle_count;
    int unsigned fail_count;
    int unsigned burst_left;
    int unsigned gap_left;

    indexed_insert_delete_list_core #(
        .DEPTH      (LIST_DEPTH),
        .DATA_WIDTH (DATA_WIDTH_DEF)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_done       (o_done),
        .o_read_value (o_read_value),
        .o_length     (o_length),
        .o_status     (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // apply one command to a list image and return the result beat it causes
    function automatic t_outcome list_apply(inout t_list_image img, input t_cmd c);
        t_outcome r;
        int       i;
        r.rd     = '0;
        r.status = ST_DONE;
        case (c.kind)
            KIND_START: begin
                // start only moves the length, the words stay put
                if (c.pos > LIST_DEPTH) r.status = ST_RANGE;
                else img.count = c.pos;
            end
            KIND_SET: begin
                if (c.pos >= img.count) begin
                    r.status = ST_RANGE;
                end else begin
                    img.words[c.pos] = c.value;
                    img.known[c.pos] = 1'b1;
                end
            end
            KIND_ERASE: begin
                if (c.pos >= img.count) begin
                    r.status = ST_RANGE;
                end else begin
                    // shift down, the old top slot keeps its word
                    for (i = c.pos; i + 1 < img.count; i++) begin
                        img.words[i] = img.words[i+1];
                        img.known[i] = img.known[i+1];
                    end
                    img.count = img.count - 1'b1;
                end
            end
            KIND_INSERT: begin
                // position check comes ahead of the capacity check
                if (c.pos > img.count) begin
                    r.status = ST_RANGE;
                end else if (img.count >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = img.count; i > c.pos; i--) begin
                        img.words[i] = img.words[i-1];
                        img.known[i] = img.known[i-1];
                    end
                    img.words[c.pos] = c.value;
                    img.known[c.pos] = 1'b1;
                    img.count = img.count + 1'b1;
                end
            end
            KIND_PUSH: begin
                if (img.count >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    img.words[img.count] = c.value;
                    img.known[img.count] = 1'b1;
                    img.count = img.count + 1'b1;
                end
            end
            KIND_READ: begin
                if (c.pos >= img.count) r.status = ST_RANGE;
                else if (img.known[c.pos]) r.rd = img.words[c.pos];
            end
            default: begin
                // spare kinds leave everything alone
            end
        endcase
        r.len = img.count;
        return r;
    endfunction

    // queue a command; a read of a never-written slot is pushed out of range
    task automatic queue_cmd(input logic [KIND_W-1:0] kind, input int pos,
                             input logic [VALUE_W-1:0] value, input bit hold);
        t_cmd     c;
        t_outcome unused;
        c.kind  = kind;
        c.pos   = pos[POS_W-1:0];
        c.value = value;
        c.hold  = hold;
        if (c.kind == KIND_READ && c.pos < gen_image.count && !gen_image.known[c.pos])
            c.pos = POS_W'($urandom_range(LIST_DEPTH, gen_image.count));
        unused = list_apply(gen_image, c);
        cmd_backlog.push_back(c);
    endtask

    function automatic logic [KIND_W-1:0] pick_kind(input bit grow);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (grow) begin
            if (r < 30) return KIND_PUSH;
            if (r < 55) return KIND_INSERT;
            if (r < 65) return KIND_ERASE;
            if (r < 75) return KIND_SET;
            if (r < 90) return KIND_READ;
            if (r < 95) return KIND_START;
        end else begin
            if (r < 35) return KIND_ERASE;
            if (r < 45) return KIND_PUSH;
            if (r < 55) return KIND_INSERT;
            if (r < 65) return KIND_SET;
            if (r < 85) return KIND_READ;
            if (r < 95) return KIND_START;
        end
        return (r[0]) ? KIND_SPARE_B : KIND_SPARE_A;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus: directed corners, then biased random traffic
    // ------------------------------------------------------------------------
    task automatic build_backlog();
        logic [KIND_W-1:0] k;
        int                p;
        bit                grow;
        int                n;

        // empty list: everything indexed is refused, insert past the end too
        queue_cmd(KIND_READ,   0, '0, 1'b0);
        queue_cmd(KIND_ERASE,  0, '0, 1'b0);
        queue_cmd(KIND_SET,    0, 32'h1111_1111, 1'b0);
        queue_cmd(KIND_INSERT, 1, 32'h2222_2222, 1'b0);
        queue_cmd(KIND_SPARE_A, 3, 32'h3333_3333, 1'b0);
        queue_cmd(KIND_SPARE_B, 31, 32'hffff_ffff, 1'b0);
        // build a short list: extremes, head insert, tail insert, middle insert
        queue_cmd(KIND_PUSH,   0, 32'h7fff_ffff, 1'b0);
        queue_cmd(KIND_PUSH,   0, 32'h8000_0000, 1'b0);
        queue_cmd(KIND_INSERT, 0, 32'hffff_ffff, 1'b0);
        queue_cmd(KIND_INSERT, 3, 32'h0000_0000, 1'b0);
        queue_cmd(KIND_INSERT, 2, 32'h1234_5678, 1'b0);
        queue_cmd(KIND_READ,   0, '0, 1'b0);
        queue_cmd(KIND_READ,   4, '0, 1'b0);
        // erase in the middle, then the last entry
        queue_cmd(KIND_ERASE,  1, '0, 1'b0);
        queue_cmd(KIND_ERASE,  3, '0, 1'b0);
        // growing the length again shows the top slots kept their words
        queue_cmd(KIND_START,  5, '0, 1'b0);
        queue_cmd(KIND_READ,   3, '0, 1'b0);
        queue_cmd(KIND_READ,   4, '0, 1'b0);
        // start beyond capacity is refused, then a full list
        queue_cmd(KIND_START,  17, '0, 1'b0);
        queue_cmd(KIND_START,  31, '0, 1'b0);
        queue_cmd(KIND_START,  LIST_DEPTH, '0, 1'b0);
        queue_cmd(KIND_PUSH,   0, 32'h5555_aaaa, 1'b0);
        queue_cmd(KIND_INSERT, 0, 32'haaaa_5555, 1'b0);
        queue_cmd(KIND_INSERT, 17, 32'h0f0f_0f0f, 1'b0);
        queue_cmd(KIND_SET,    LIST_DEPTH - 1, 32'h8000_0001, 1'b0);
        queue_cmd(KIND_READ,   LIST_DEPTH - 1, '0, 1'b0);
        // longest shift down
        queue_cmd(KIND_ERASE,  0, '0, 1'b0);

        grow = 1'b1;
        for (n = 0; n < RANDOM_CMDS; n++) begin
            if (n % 60 == 0) grow = $urandom_range(0, 1);
            k = pick_kind(grow);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: p = $urandom_range(0, gen_image.count);
                7, 8:                p = $urandom_range(0, LIST_DEPTH);
                default:             p = (k == KIND_START) ? $urandom_range(0, 31)
                                                           : $urandom_range(0, LIST_DEPTH);
            endcase
            // pause for an idle core at the head of random traffic and midway
            queue_cmd(k, p, pick_value(), (n == 0) || (n == RANDOM_CMDS / 2));
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: one command beat per accept, bursts with random gaps
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_cmd c;
        bit   waiting;
        waiting = start && (beats_in != beats_sent);
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!waiting) begin
            if (gap_left > 0) begin
                gap_left--;
                start      <= 1'b0;
                i_kind     <= KIND_W'($urandom());
                i_position <= POS_W'($urandom());
                i_value    <= $urandom();
            end else if (cmd_backlog.size() > 0 &&
                         !(cmd_backlog[0].hold && outcome_fifo.size() > 0)) begin
                c = cmd_backlog.pop_front();
                start      <= 1'b1;
                i_kind     <= c.kind;
                i_position <= c.pos;
                i_value    <= c.value;
                beats_sent++;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    // a quarter of the bursts run straight into the next one
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    burst_left = $urandom_range(1, 40);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: check result beats, then predict for a command beat taken now
    // ------------------------------------------------------------------------
    task automatic report_fail(input string what, input t_outcome want, input t_outcome got);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%s at cycle %0d: want rd=%h len=%0d st=%0d got rd=%h len=%0d st=%0d",
                     what, cycle_count, want.rd, want.len, want.status,
                     got.rd, got.len, got.status);
    endtask

    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        t_cmd     c;
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else if (i_rst_n) begin
            if (o_done === 1'b1) begin
                got.rd     = o_read_value;
                got.len    = o_length;
                got.status = o_status;
                if (outcome_fifo.size() == 0) begin
                    report_fail("unexpected result beat", '0, got);
                end else begin
                    want = outcome_fifo.pop_front();
                    if (got.rd !== want.rd || got.len !== want.len ||
                        got.status !== want.status)
                        report_fail("result mismatch", want, got);
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                c.kind  = i_kind;
                c.pos   = i_position;
                c.value = i_value;
                c.hold  = 1'b0;
                outcome_fifo.push_back(list_apply(core_image, c));
                beats_in++;
            end
        end
    end

    initial begin
        start       = 1'b0;
        i_kind      = '0;
        i_position  = '0;
        i_value     = '0;
        i_rst_n     = 1'b0;
        beats_sent  = 0;
        beats_in    = 0;
        cycle_count = 0;
        fail_count  = 0;
        burst_left  = $urandom_range(1, 40);
        gap_left    = 0;
        gen_image   = '0;
        core_image  = '0;
        build_backlog();
        cmd_total = cmd_backlog.size();

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all beats taken and every prediction matched by a result
        while (beats_in < cmd_total || outcome_fifo.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (outcome_fifo.size() > 0) fail_count++;

        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
